FILE: rtl/core/thlin_pkg.sv
// shared types, constants and the coefficient table of the thermocouple linearizer
`timescale 1ns / 1ps
`default_nettype none

package thlin_pkg;

  // polynomial length and coefficient table geometry
  localparam int NUM_TERMS = 10;
  localparam int COL_W     = 4;
  localparam int TYPE_W    = 3;

  // datapath widths
  localparam int ACC_W   = 64;
  localparam int V_W     = 18;
  localparam int MAG_W   = 62;
  localparam int HALF_W  = 31;
  localparam int PP_W    = HALF_W + V_W;
  localparam int PROD_W  = 80;
  localparam int DROP_W  = 5;
  localparam int CHUNK_W = 19;
  localparam int NUM_CHUNKS = 4;
  localparam int MQ_W    = CHUNK_W * NUM_CHUNKS;
  localparam int CELL_LAT = 6 + 2 * NUM_CHUNKS;
  localparam int CONV_LAT = 5;

  // divide by 3125 through a reciprocal and one correction
  localparam int DIV_X_W  = 31;
  localparam int DIV_Q_W  = 20;
  localparam int DIV_R_W  = 12;
  localparam int DIVISOR  = 3125;
  localparam int RECIP_SH = 31;
  localparam int RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / DIVISOR);

  // accumulator saturation in micro-degrees
  localparam logic signed [ACC_W-1:0] ACC_LIMIT = 64'sd4000000000000000000;

  // output field widths
  localparam int C_W = 19;
  localparam int F_W = 20;
  localparam int K_W = 18;

  // thermocouple type codes
  localparam logic [TYPE_W-1:0] TC_J = 3'd0;
  localparam logic [TYPE_W-1:0] TC_K = 3'd1;
  localparam logic [TYPE_W-1:0] TC_E = 3'd2;
  localparam logic [TYPE_W-1:0] TC_R = 3'd3;
  localparam logic [TYPE_W-1:0] TC_S = 3'd4;
  localparam logic [TYPE_W-1:0] TC_T = 3'd5;

  // beat handed from one cell to the next
  typedef struct packed {
    logic signed [ACC_W-1:0] s;
    logic signed [V_W-1:0]   v;
  } beat_t;

  // side data riding along the long division inside a cell
  typedef struct packed {
    logic                  neg;
    logic                  lnz;
    logic signed [V_W-1:0] v;
    logic [MQ_W-1:0]       mq;
  } side_t;

  // coefficient in micro-degrees for a type and power of the 0.1 V variable
  function automatic logic signed [ACC_W-1:0] coef_lookup(input logic [TYPE_W-1:0] row,
                                                         input logic [COL_W-1:0] col);
    logic signed [ACC_W-1:0] c;
    c = '0;
    unique case (row)
      TC_J: begin
        unique case (col)
          4'd0: c = -64'sd48868;
          4'd1: c = 64'sd1987314503;
          4'd2: c = -64'sd2186145353;
          4'd3: c = 64'sd11569199780;
          4'd4: c = -64'sd26491753140;
          4'd5: c = 64'sd20184413140;
          default: c = '0;
        endcase
      end
      TC_K: begin
        unique case (col)
          4'd0: c = 64'sd226585;
          4'd1: c = 64'sd2415210900;
          4'd2: c = 64'sd672334248;
          4'd3: c = 64'sd2210340682;
          4'd4: c = -64'sd86096391490;
          4'd5: c = 64'sd483506000000;
          4'd6: c = -64'sd1184520000000;
          4'd7: c = 64'sd1386900000000;
          4'd8: c = -64'sd633708000000;
          default: c = '0;
        endcase
      end
      TC_E: begin
        unique case (col)
          4'd0: c = 64'sd104967;
          4'd1: c = 64'sd1718945282;
          4'd2: c = -64'sd2826390850;
          4'd3: c = 64'sd12695339500;
          4'd4: c = -64'sd44870308460;
          4'd5: c = 64'sd110866000000;
          4'd6: c = -64'sd176807000000;
          4'd7: c = 64'sd171842000000;
          4'd8: c = -64'sd91927800000;
          4'd9: c = 64'sd20613200000;
          default: c = '0;
        endcase
      end
      TC_R: begin
        unique case (col)
          4'd0: c = 64'sd263633;
          4'd1: c = 64'sd17907549100;
          4'd2: c = -64'sd488403413700;
          4'd3: c = 64'sd19000200000000;
          4'd4: c = -64'sd482704000000000;
          4'd5: c = 64'sd7620910000000000;
          4'd6: c = -64'sd72002600000000000;
          4'd7: c = 64'sd371496000000000000;
          4'd8: c = -64'sd803104000000000000;
          default: c = '0;
        endcase
      end
      TC_S: begin
        unique case (col)
          4'd0: c = 64'sd927763;
          4'd1: c = 64'sd16952651500;
          4'd2: c = -64'sd315683639400;
          4'd3: c = 64'sd8990730663000;
          4'd4: c = -64'sd163565000000000;
          4'd5: c = 64'sd1880270000000000;
          4'd6: c = -64'sd13724100000000000;
          4'd7: c = 64'sd61750100000000000;
          4'd8: c = -64'sd156105000000000000;
          4'd9: c = 64'sd169535000000000000;
          default: c = '0;
        endcase
      end
      TC_T: begin
        unique case (col)
          4'd0: c = 64'sd100861;
          4'd1: c = 64'sd2572794369;
          4'd2: c = -64'sd7673458295;
          4'd3: c = 64'sd78025595810;
          4'd4: c = -64'sd924748658900;
          4'd5: c = 64'sd6976880000000;
          4'd6: c = -64'sd26619200000000;
          4'd7: c = 64'sd39407800000000;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/thermocouple_linearizer_unit.sv
// top level of the thermocouple linearizer: type register, horner cell row, conversion
//
// use
//   a sample on voltage_microvolts (signed microvolts, cold junction at 0 C) is taken
//   at a rising edge where start is high and busy is low. busy is set while rst is
//   held and clears at the next edge without rst, so a new sample may follow every
//   cycle: the block takes one beat per clock.
//   each sample yields one result: done is high for exactly one cycle with
//   celsius_centi, fahrenheit_centi and kelvin_centi valid, saturated to their ranges.
//   each sample passes the row of horner cells, each a 14-stage pipeline (two half
//   products, four steps of a chunked divide by 100000, sign fix and coefficient
//   add), and then a five-stage conversion. results leave in the order samples
//   came in; there is no back pressure from the receiver and no buffering.
//   cfg_wr_en writes cfg_wr_data into the thermocouple type (0 J, 1 K, 2 E,
//   3 R, 4 S, 5 T, others a zero polynomial); write it only with no beat in flight.
//   rst clears the type to J and drops every beat in flight.
`timescale 1ns / 1ps
`default_nettype none

module thermocouple_linearizer_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [thlin_pkg::V_W-1:0]       voltage_microvolts,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [thlin_pkg::TYPE_W-1:0]    cfg_wr_data,
  output logic                                        done,
  output logic signed [thlin_pkg::C_W-1:0]            celsius_centi,
  output logic signed [thlin_pkg::F_W-1:0]            fahrenheit_centi,
  output logic        [thlin_pkg::K_W-1:0]            kelvin_centi
);
  import thlin_pkg::*;

  logic [TYPE_W-1:0] couple_type;
  beat_t             chain [NUM_TERMS+1];
  logic              chain_vld [NUM_TERMS+1];

  // type register and busy after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      couple_type <= TC_J;
      busy        <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        couple_type <= cfg_wr_data;
      end
      busy <= 1'b0;
    end
  end

  // accumulator starts at zero
  assign chain_vld[0] = start && !busy;
  assign chain[0].s   = '0;
  assign chain[0].v   = voltage_microvolts;

  // highest power first down to the constant term
  for (genvar i = 0; i < NUM_TERMS; i++) begin : g_cell
    thlin_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (chain_vld[i]),
      .beat_in  (chain[i]),
      .coef     (coef_lookup(couple_type, COL_W'(NUM_TERMS - 1 - i))),
      .vld_out  (chain_vld[i+1]),
      .beat_out (chain[i+1])
    );
  end

  thlin_conv u_conv (
    .clk     (clk),
    .rst     (rst),
    .vld_in  (chain_vld[NUM_TERMS]),
    .s_in    (chain[NUM_TERMS].s),
    .vld_out (done),
    .c_out   (celsius_centi),
    .f_out   (fahrenheit_centi),
    .k_out   (kelvin_centi)
  );

endmodule

`default_nettype wire

FILE: rtl/core/thlin_div_step.sv
// two-stage divide of a 31-bit value by 3125: quotient and remainder
`timescale 1ns / 1ps
`default_nettype none

module thlin_div_step (
  input  wire logic                           clk,
  input  wire logic [thlin_pkg::DIV_X_W-1:0]  x,
  output logic      [thlin_pkg::DIV_Q_W-1:0]  q,
  output logic      [thlin_pkg::DIV_R_W-1:0]  r
);
  import thlin_pkg::*;

  localparam int PR_W = DIV_X_W + RECIP_W;
  localparam int RF_W = DIV_R_W + 1;

  logic [DIV_X_W-1:0] x_d;
  logic [DIV_Q_W-1:0] q0;
  logic [PR_W-1:0]    prod;
  logic [DIV_X_W-1:0] back;
  logic [RF_W-1:0]    r_full;

  // estimate from the reciprocal, never above the true quotient
  assign prod = PR_W'(x) * PR_W'(RECIP);

  always_ff @(posedge clk) begin
    x_d <= x;
    q0  <= prod[PR_W-1 -: DIV_Q_W];
  end

  // remainder of the estimate, one correction step
  assign back   = DIV_X_W'(q0) * DIV_X_W'(DIVISOR);
  assign r_full = RF_W'(x_d - back);

  always_ff @(posedge clk) begin
    if (r_full >= RF_W'(DIVISOR)) begin
      q <= q0 + DIV_Q_W'(1);
      r <= DIV_R_W'(r_full - RF_W'(DIVISOR));
    end else begin
      q <= q0;
      r <= DIV_R_W'(r_full);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/thlin_cell.sv
// one horner cell: s_out = sat(floor(s_in * v / 100000) + coef), fully pipelined
`timescale 1ns / 1ps
`default_nettype none

module thlin_cell (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                vld_in,
  input  wire thlin_pkg::beat_t                    beat_in,
  input  wire logic signed [thlin_pkg::ACC_W-1:0]  coef,
  output logic                                     vld_out,
  output thlin_pkg::beat_t                         beat_out
);
  import thlin_pkg::*;

  localparam int T_W = ACC_W + 1;
  localparam int S_W = ACC_W + 2;
  localparam logic signed [S_W-1:0] LIM = S_W'(ACC_LIMIT);

  logic [CELL_LAT-1:0] vld_pipe;

  // stage 1: magnitudes and product sign
  logic [MAG_W-1:0]      mag1;
  logic [V_W-1:0]        b1;
  logic                  neg1;
  logic signed [V_W-1:0] v1;

  // stages 2 and 3: partial products
  logic [HALF_W-1:0]     mag_hi2;
  logic [V_W-1:0]        b2;
  logic [PP_W-1:0]       plo2;
  logic                  neg2;
  logic signed [V_W-1:0] v2;
  logic [PP_W-1:0]       plo3;
  logic [PP_W-1:0]       phi3;
  logic                  neg3;
  logic signed [V_W-1:0] v3;

  // stage 4 and the division chain
  logic [PROD_W-1:0]  m_sum;
  side_t              sd [NUM_CHUNKS+1];
  side_t              sa [NUM_CHUNKS];
  side_t              sb [NUM_CHUNKS];
  logic [DIV_Q_W-1:0] q_chunk [NUM_CHUNKS];
  logic [DIV_R_W-1:0] r_chunk [NUM_CHUNKS];

  // finish stages
  logic [ACC_W-1:0]      quo;
  logic                  exact;
  logic signed [T_W-1:0] t_next;
  logic signed [T_W-1:0] t;
  logic signed [V_W-1:0] v_f;
  logic signed [S_W-1:0] sum;

  // valid travels alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[CELL_LAT-2:0], vld_in};
    end
  end

  assign vld_out = vld_pipe[CELL_LAT-1];

  // magnitudes of accumulator and sample
  always_ff @(posedge clk) begin
    mag1 <= beat_in.s[ACC_W-1] ? MAG_W'(-beat_in.s) : MAG_W'(beat_in.s);
    b1   <= beat_in.v[V_W-1] ? V_W'(-beat_in.v) : V_W'(beat_in.v);
    neg1 <= beat_in.s[ACC_W-1] ^ beat_in.v[V_W-1];
    v1   <= beat_in.v;
  end

  // low half product
  always_ff @(posedge clk) begin
    plo2    <= PP_W'(mag1[HALF_W-1:0]) * PP_W'(b1);
    mag_hi2 <= mag1[MAG_W-1:HALF_W];
    b2      <= b1;
    neg2    <= neg1;
    v2      <= v1;
  end

  // high half product
  always_ff @(posedge clk) begin
    phi3 <= PP_W'(mag_hi2) * PP_W'(b2);
    plo3 <= plo2;
    neg3 <= neg2;
    v3   <= v2;
  end

  // combine halves, drop the factor of 32 ahead of the divide by 3125
  assign m_sum = (PROD_W'(phi3) << HALF_W) + PROD_W'(plo3);

  always_ff @(posedge clk) begin
    sd[0].mq  <= MQ_W'(m_sum >> DROP_W);
    sd[0].lnz <= |m_sum[DROP_W-1:0];
    sd[0].neg <= neg3;
    sd[0].v   <= v3;
  end

  // long division, one 19-bit chunk per step, quotient written in place
  for (genvar j = 0; j < NUM_CHUNKS; j++) begin : g_chunk
    localparam int HI = MQ_W - 1 - CHUNK_W * j;
    logic [DIV_X_W-1:0] x_in;

    if (j == 0) begin : g_first
      assign x_in = DIV_X_W'(sd[j].mq[HI -: CHUNK_W]);
    end else begin : g_rest
      assign x_in = {r_chunk[j-1], sd[j].mq[HI -: CHUNK_W]};
    end

    thlin_div_step u_step (
      .clk (clk),
      .x   (x_in),
      .q   (q_chunk[j]),
      .r   (r_chunk[j])
    );

    always_ff @(posedge clk) begin
      sa[j] <= sd[j];
      sb[j] <= sa[j];
    end

    always_comb begin
      sd[j+1] = sb[j];
      sd[j+1].mq[HI -: CHUNK_W] = q_chunk[j][CHUNK_W-1:0];
    end
  end

  // floor of the signed quotient
  assign quo   = sd[NUM_CHUNKS].mq[ACC_W-1:0];
  assign exact = (r_chunk[NUM_CHUNKS-1] == '0) && !sd[NUM_CHUNKS].lnz;

  always_comb begin
    if (!sd[NUM_CHUNKS].neg) begin
      t_next = $signed({1'b0, quo});
    end else if (exact) begin
      t_next = -$signed({1'b0, quo});
    end else begin
      t_next = ~$signed({1'b0, quo});
    end
  end

  always_ff @(posedge clk) begin
    t   <= t_next;
    v_f <= sd[NUM_CHUNKS].v;
  end

  // add coefficient and saturate
  assign sum = S_W'(t) + S_W'(coef);

  always_ff @(posedge clk) begin
    if (sum > LIM) begin
      beat_out.s <= ACC_LIMIT;
    end else if (sum < -LIM) begin
      beat_out.s <= -ACC_LIMIT;
    end else begin
      beat_out.s <= ACC_W'(sum);
    end
    beat_out.v <= v_f;
  end

endmodule

`default_nettype wire

FILE: rtl/core/thlin_conv.sv
// converts micro-degrees celsius to saturated centi celsius, fahrenheit and kelvin
`timescale 1ns / 1ps
`default_nettype none

module thlin_conv (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                vld_in,
  input  wire logic signed [thlin_pkg::ACC_W-1:0]  s_in,
  output logic                                     vld_out,
  output logic signed [thlin_pkg::C_W-1:0]         c_out,
  output logic signed [thlin_pkg::F_W-1:0]         f_out,
  output logic        [thlin_pkg::K_W-1:0]         k_out
);
  import thlin_pkg::*;

  // outside [-4e8, 2.1e9] every output is already saturated
  localparam logic signed [ACC_W-1:0] S_LO = -64'sd400000000;
  localparam logic signed [ACC_W-1:0] S_HI = 64'sd2100000000;
  localparam int SC_W = 32;
  localparam logic [SC_W-1:0] SC_OFS = 32'd400000000;
  localparam logic [SC_W-1:0] SC_TOP = 32'd2500000000;
  localparam logic [SC_W-1:0] C_RND  = 32'd5000;
  localparam logic [SC_W-1:0] K_RND  = 32'd273155000;
  localparam int NF_W = 35;
  localparam logic [NF_W-1:0] F_RND = 35'd160025000;
  localparam int SH = 4;
  localparam int O_W = 22;
  localparam logic signed [O_W-1:0] C_BIAS = 22'sd40000;
  localparam logic signed [O_W-1:0] F_BIAS = 22'sd72000;
  localparam logic signed [O_W-1:0] C_MIN = -22'sd30000;
  localparam logic signed [O_W-1:0] C_MAX = 22'sd200000;
  localparam logic signed [O_W-1:0] F_MIN = -22'sd46000;
  localparam logic signed [O_W-1:0] F_MAX = 22'sd364000;
  localparam logic signed [O_W-1:0] K_MAX = 22'sd227315;

  logic [CONV_LAT-1:0] vld_pipe;
  logic [SC_W-1:0]     sc;
  logic [SC_W-1:0]     nc;
  logic [SC_W-1:0]     nk;
  logic [NF_W-1:0]     nf;
  logic [SC_W-1:0]     yc;
  logic [SC_W-1:0]     yk;
  logic [DIV_X_W-1:0]  xc;
  logic [DIV_X_W-1:0]  xk;
  logic [DIV_X_W-1:0]  xf;
  logic [DIV_Q_W-1:0]  qc;
  logic [DIV_Q_W-1:0]  qk;
  logic [DIV_Q_W-1:0]  qf;
  logic [DIV_R_W-1:0]  rc;
  logic [DIV_R_W-1:0]  rk;
  logic [DIV_R_W-1:0]  rf;
  logic signed [O_W-1:0] cw;
  logic signed [O_W-1:0] fw;
  logic signed [O_W-1:0] kw;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[CONV_LAT-2:0], vld_in};
    end
  end

  assign vld_out = vld_pipe[CONV_LAT-1];

  // clamp and shift to a non-negative range
  always_ff @(posedge clk) begin
    if (s_in < S_LO) begin
      sc <= '0;
    end else if (s_in > S_HI) begin
      sc <= SC_TOP;
    end else begin
      sc <= SC_W'(s_in + ACC_W'(SC_OFS));
    end
  end

  // rounding offsets; /10000 becomes 5 * floor(n / 16) / 3125
  assign nc = sc + C_RND;
  assign nk = sc + K_RND;
  assign nf = (NF_W'(sc) << 3) + NF_W'(sc) + F_RND;
  assign yc = nc >> SH;
  assign yk = nk >> SH;

  always_ff @(posedge clk) begin
    xc <= DIV_X_W'((yc << 2) + yc);
    xk <= DIV_X_W'((yk << 2) + yk);
    xf <= DIV_X_W'(nf >> SH);
  end

  thlin_div_step u_div_c (.clk(clk), .x(xc), .q(qc), .r(rc));
  thlin_div_step u_div_f (.clk(clk), .x(xf), .q(qf), .r(rf));
  thlin_div_step u_div_k (.clk(clk), .x(xk), .q(qk), .r(rk));

  // remove the range shift and saturate; the kelvin clamp also looks at the remainders
  assign cw = $signed(O_W'(qc)) - C_BIAS;
  assign fw = $signed(O_W'(qf)) - F_BIAS;
  assign kw = $signed(O_W'(qk)) - C_BIAS;

  always_ff @(posedge clk) begin
    if (cw < C_MIN) begin
      c_out <= C_W'(C_MIN);
    end else if (cw > C_MAX) begin
      c_out <= C_W'(C_MAX);
    end else begin
      c_out <= C_W'(cw);
    end
    if (fw < F_MIN) begin
      f_out <= F_W'(F_MIN);
    end else if (fw > F_MAX) begin
      f_out <= F_W'(F_MAX);
    end else begin
      f_out <= F_W'(fw);
    end
    if (kw[O_W-1] || (rc == '0 && rf == '0 && rk == '0 && kw == '0)) begin
      k_out <= '0;
    end else if (kw > K_MAX) begin
      k_out <= K_W'(K_MAX);
    end else begin
      k_out <= K_W'(kw);
    end
  end

endmodule

`default_nettype wire
